>>> src/lkvc_pkg.sv
package lkvc_pkg;

  localparam int KeyW = 64;
  localparam int KeyLenW = 4;
  localparam int ValW = 64;
  localparam int ValLenW = 8;
  localparam int HitsW = 32;
  localparam int CountW = 5;
  localparam int BytesW = 16;

  localparam logic [HitsW-1:0] LEAST_HITS_CEIL = 32'd9999999;

  localparam logic [1:0] F_GET = 2'd0;
  localparam logic [1:0] F_SET = 2'd1;
  localparam logic [1:0] F_DEL = 2'd2;
  localparam logic [1:0] F_RST = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_NO_SPACE = 2'd3;

  typedef struct packed {
    logic [HitsW-1:0] hits;
    logic [ValLenW-1:0] value_len;
    logic [ValW-1:0] value;
    logic [KeyLenW-1:0] key_len;
    logic [KeyW-1:0] key;
  } entry_t;

endpackage

>>> src/lkvc_ram.sv
module lkvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/lfu_key_value_cache.sv
// Fully associative key-value cache with least-frequently-used eviction.
// One item (get, set, delete or reset-all, selected by s_axis_tuser) is
// handled at a time. All slot contents and hit counts sit in one RAM with a
// single read port, so every item walks the ENTRIES slots one per cycle to
// find the matching key, the lowest free slot and the least-hit victim, then
// writes back; the write-back waits while an earlier result still waits on
// m_axis_tready. Slots holding LEAST_HITS_CEIL hits or more are never
// evicted. Each result carries the running totals after that item. No
// clearing pass is needed after reset; valid bits live in flip-flops.
module lfu_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int KEY_BYTES = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata,     // max_value_len
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,  // key[63:0], key_len[67:64], value_word[131:68],
                                      // value_len[139:132], zero pad
  input  logic [1:0]   s_axis_tuser,  // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [215:0] m_axis_tdata,  // read_value[63:0], hits_total[95:64],
                                      // accesses_total[127:96], sets_total[159:128],
                                      // evictions_total[191:160], key_count[196:192],
                                      // bytes_used[212:197], zero pad
  output logic [1:0]   m_axis_tuser   // status
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = $bits(entry_t);
  localparam logic [CW-1:0] LastCnt = CW'(ENTRIES);
  localparam logic [KeyW-1:0] KeyMask = {KeyW{1'b1}} >> (KeyW - 8 * KEY_BYTES);
  localparam logic [KeyLenW-1:0] KeyBytesL = KeyLenW'(KEY_BYTES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0] state;

  logic [ValLenW-1:0] max_len;

  logic [1:0]          func_r;
  logic [KeyW-1:0]     key_r;
  logic [KeyLenW-1:0]  kl_r;
  logic [ValW-1:0]     val_r;
  logic [ValLenW-1:0]  vl_r;

  logic [CW-1:0]       scan_cnt;
  logic                chk_vld;
  logic [IW-1:0]       chk_idx;
  logic                match_found;
  logic [IW-1:0]       match_idx;
  entry_t              match_ent;
  logic                free_found;
  logic [IW-1:0]       free_idx;
  logic                victim_found;
  logic [IW-1:0]       victim_idx;
  logic [KeyLenW-1:0]  victim_kl;
  logic [ValLenW-1:0]  victim_vl;
  logic [HitsW-1:0]    least;

  logic [ENTRIES-1:0]  valid;
  logic [HitsW-1:0]    hit_cnt;
  logic [HitsW-1:0]    acc_cnt;
  logic [HitsW-1:0]    set_cnt;
  logic [HitsW-1:0]    ev_cnt;
  logic [CountW-1:0]   occ;
  logic [BytesW-1:0]   bytes;

  logic                out_valid;
  logic [1:0]          out_status;
  logic [ValW-1:0]     out_rv;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  entry_t              ram_went;
  logic [IW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_rdata;
  entry_t              rd_ent;

  // write-back decision
  logic                go;
  logic [1:0]          st_next;
  logic [ValW-1:0]     rv_next;
  logic                inc_hit, inc_acc, inc_set, inc_ev;
  logic                set_v, clr_v, clr_all;
  logic [CountW-1:0]   occ_next;
  logic [BytesW-1:0]   bytes_next;
  logic [BytesW-1:0]   new_bytes;

  logic                in_fire;
  logic [KeyLenW-1:0]  in_kl;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_kl = (s_axis_tdata[67:64] > KeyBytesL) ? KeyBytesL : s_axis_tdata[67:64];

  assign ram_raddr = scan_cnt[IW-1:0];
  assign rd_ent = entry_t'(ram_rdata);

  lkvc_ram #(
    .WIDTH(EW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_went),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign go = (state == S_WRITE) && (!out_valid || m_axis_tready);
  assign new_bytes = BytesW'(kl_r) + BytesW'(vl_r);

  always_comb begin
    st_next = ST_OK;
    rv_next = '0;
    ram_we = 1'b0;
    ram_waddr = match_idx;
    ram_went = match_ent;
    inc_hit = 1'b0;
    inc_acc = 1'b0;
    inc_set = 1'b0;
    inc_ev = 1'b0;
    set_v = 1'b0;
    clr_v = 1'b0;
    clr_all = 1'b0;
    occ_next = occ;
    bytes_next = bytes;
    unique case (func_r)
      F_GET: begin
        inc_acc = 1'b1;
        if (match_found) begin
          inc_hit = 1'b1;
          ram_we = go;
          ram_went.hits = match_ent.hits + 1'b1;
          rv_next = match_ent.value;
        end else begin
          st_next = ST_NOT_FOUND;
        end
      end
      F_SET: begin
        ram_went.key = key_r;
        ram_went.key_len = kl_r;
        ram_went.value = val_r;
        ram_went.value_len = vl_r;
        if (vl_r > max_len) begin
          st_next = ST_TOO_LONG;
        end else if (key_r == '0) begin
          st_next = ST_NOT_FOUND;
        end else if (match_found) begin
          ram_we = go;
          inc_set = 1'b1;
          bytes_next = bytes - BytesW'(match_ent.key_len) - BytesW'(match_ent.value_len)
                       + new_bytes;
        end else if (free_found) begin
          ram_we = go;
          ram_waddr = free_idx;
          ram_went.hits = '0;
          set_v = 1'b1;
          inc_set = 1'b1;
          occ_next = occ + 1'b1;
          bytes_next = bytes + new_bytes;
        end else if (victim_found) begin
          ram_we = go;
          ram_waddr = victim_idx;
          ram_went.hits = '0;
          inc_set = 1'b1;
          inc_ev = 1'b1;
          bytes_next = bytes - BytesW'(victim_kl) - BytesW'(victim_vl) + new_bytes;
        end else begin
          st_next = ST_NO_SPACE;
        end
      end
      F_DEL: begin
        if (match_found) begin
          clr_v = 1'b1;
          occ_next = occ - 1'b1;
          bytes_next = bytes - BytesW'(match_ent.key_len) - BytesW'(match_ent.value_len);
        end else begin
          st_next = ST_NOT_FOUND;
        end
      end
      F_RST: begin
        clr_all = 1'b1;
        occ_next = '0;
        bytes_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_len <= 8'd255;
      func_r <= F_GET;
      valid <= '0;
      hit_cnt <= '0;
      acc_cnt <= '0;
      set_cnt <= '0;
      ev_cnt <= '0;
      occ <= '0;
      bytes <= '0;
      out_valid <= 1'b0;
      chk_vld <= 1'b0;
      scan_cnt <= '0;
    end else begin
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready && !go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            func_r <= s_axis_tuser;
            key_r <= s_axis_tdata[63:0] & KeyMask;
            kl_r <= in_kl;
            val_r <= s_axis_tdata[131:68];
            vl_r <= s_axis_tdata[139:132];
            scan_cnt <= '0;
            chk_vld <= 1'b0;
            match_found <= 1'b0;
            free_found <= 1'b0;
            victim_found <= 1'b0;
            least <= LEAST_HITS_CEIL;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read issued at scan_cnt, checked in the cycle after at chk_idx
          if (scan_cnt != LastCnt) begin
            chk_vld <= 1'b1;
            chk_idx <= scan_cnt[IW-1:0];
            scan_cnt <= scan_cnt + 1'b1;
          end else begin
            chk_vld <= 1'b0;
            state <= S_WRITE;
          end
          if (chk_vld) begin
            if (valid[chk_idx]) begin
              if (!match_found && key_r != '0 && rd_ent.key == key_r) begin
                match_found <= 1'b1;
                match_idx <= chk_idx;
                match_ent <= rd_ent;
              end
              // strict compare keeps the lowest index on ties
              if (rd_ent.hits < least) begin
                least <= rd_ent.hits;
                victim_found <= 1'b1;
                victim_idx <= chk_idx;
                victim_kl <= rd_ent.key_len;
                victim_vl <= rd_ent.value_len;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_idx <= chk_idx;
            end
          end
        end
        S_WRITE: begin
          if (go) begin
            if (clr_all) begin
              valid <= '0;
            end else if (set_v) begin
              valid[ram_waddr] <= 1'b1;
            end else if (clr_v) begin
              valid[ram_waddr] <= 1'b0;
            end
            if (inc_hit) hit_cnt <= hit_cnt + 1'b1;
            if (inc_acc) acc_cnt <= acc_cnt + 1'b1;
            if (inc_set) set_cnt <= set_cnt + 1'b1;
            if (inc_ev) ev_cnt <= ev_cnt + 1'b1;
            occ <= occ_next;
            bytes <= bytes_next;
            out_valid <= 1'b1;
            out_status <= st_next;
            out_rv <= rv_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {3'b000, bytes, occ, ev_cnt, set_cnt, acc_cnt, hit_cnt, out_rv};

  // occupancy tracks the valid bits (modulo the count width)
  a_occ_matches: assert property (@(posedge clk) disable iff (rst)
    occ == CountW'($countones(valid)))
    else $error("occupied count out of step with valid bits");

  a_we_in_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_WRITE) && (!out_valid || m_axis_tready))
    else $error("RAM written outside write-back");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && (scan_cnt == LastCnt) |-> chk_vld && (chk_idx == IW'(ENTRIES - 1)))
    else $error("scan left before the last slot was checked");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (state == S_IDLE) && $past(state == S_WRITE))
    else $error("result issued outside write-back");

endmodule

>>> tb/lfu_key_value_cache_tb.sv
module lfu_key_value_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int Entries = 16;
  localparam int KeyBytes = 8;
  localparam int PoolSize = 24;       // more keys than slots, so sets must evict
  localparam int DrainCycles = 60;    // longer than the time for one item
  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [1:0]         status;
    logic [ValW-1:0]    read_value;
    logic [HitsW-1:0]   hits;
    logic [HitsW-1:0]   accesses;
    logic [HitsW-1:0]   sets;
    logic [HitsW-1:0]   evictions;
    logic [CountW-1:0]  key_count;
    logic [BytesW-1:0]  bytes_used;
  } result_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [7:0]   cfg_wdata = 8'd0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;  // key, key_len, value_word, value_len, pad
  logic [1:0]   s_axis_tuser = F_GET;  // func
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [215:0] m_axis_tdata;  // read_value, hits, accesses, sets, evictions, key_count,
                               // bytes_used, pad
  logic [1:0]   m_axis_tuser;  // status

  lfu_key_value_cache #(
    .ENTRIES(Entries),
    .KEY_BYTES(KeyBytes)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cache shadow
  logic [7:0]         limit_q = 8'd255;
  bit                 slot_used[Entries] = '{default: 1'b0};
  logic [KeyW-1:0]    slot_key_q[Entries] = '{default: '0};
  logic [KeyLenW-1:0] slot_klen[Entries] = '{default: '0};
  logic [ValW-1:0]    slot_val[Entries] = '{default: '0};
  logic [ValLenW-1:0] slot_vlen[Entries] = '{default: '0};
  logic [HitsW-1:0]   slot_hit_cnt[Entries] = '{default: '0};
  logic [HitsW-1:0]   hit_total = '0;
  logic [HitsW-1:0]   access_total = '0;
  logic [HitsW-1:0]   set_total = '0;
  logic [HitsW-1:0]   evict_total = '0;
  logic [CountW-1:0]  occupied = '0;
  logic [BytesW-1:0]  byte_sum = '0;

  result_t            pending_results[$];
  logic [KeyW-1:0]    key_pool[PoolSize];
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 recv_hold_req = 0;
  int                 error_count = 0;
  int                 results_seen = 0;

  function automatic int find_key(logic [KeyW-1:0] key);
    int idx;
    idx = -1;
    if (key != '0) begin
      for (int i = 0; i < Entries; i++) begin
        if (idx < 0 && slot_used[i] && slot_key_q[i] == key) idx = i;
      end
    end
    return idx;
  endfunction

  function automatic logic [BytesW-1:0] entry_bytes(int i);
    return BytesW'(slot_klen[i]) + BytesW'(slot_vlen[i]);
  endfunction

  function automatic void store_entry(int i, logic [KeyW-1:0] key, logic [KeyLenW-1:0] kl,
                                      logic [ValW-1:0] val, logic [ValLenW-1:0] vlen);
    slot_key_q[i] = key;
    slot_klen[i] = kl;
    slot_val[i] = val;
    slot_vlen[i] = vlen;
  endfunction

  // Applies one operation to the shadow and returns the result it must produce.
  function automatic result_t cache_apply(logic [1:0] op, logic [KeyW-1:0] key,
                                          logic [KeyLenW-1:0] klen, logic [ValW-1:0] val,
                                          logic [ValLenW-1:0] vlen);
    result_t r;
    int m;
    int free_i;
    int victim;
    logic [HitsW-1:0] least;
    logic [KeyLenW-1:0] kl;
    r = '0;
    r.status = ST_OK;
    kl = (klen > KeyLenW'(KeyBytes)) ? KeyLenW'(KeyBytes) : klen;
    m = find_key(key);
    case (op)
      F_GET: begin
        access_total++;
        if (m >= 0) begin
          hit_total++;
          slot_hit_cnt[m]++;
          r.read_value = slot_val[m];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      F_SET: begin
        if (vlen > limit_q) begin
          r.status = ST_TOO_LONG;
        end else if (key == '0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          free_i = -1;
          victim = -1;
          least = LEAST_HITS_CEIL;
          for (int i = 0; i < Entries; i++) begin
            if (!slot_used[i]) begin
              if (free_i < 0) free_i = i;
            end else if (slot_hit_cnt[i] < least) begin
              least = slot_hit_cnt[i];
              victim = i;
            end
          end
          if (m >= 0) begin
            byte_sum -= entry_bytes(m);
            store_entry(m, key, kl, val, vlen);
            byte_sum += entry_bytes(m);
            set_total++;
          end else if (free_i >= 0) begin
            store_entry(free_i, key, kl, val, vlen);
            slot_used[free_i] = 1'b1;
            slot_hit_cnt[free_i] = '0;
            byte_sum += entry_bytes(free_i);
            occupied++;
            set_total++;
          end else if (victim >= 0) begin
            byte_sum -= entry_bytes(victim);
            store_entry(victim, key, kl, val, vlen);
            slot_hit_cnt[victim] = '0;
            byte_sum += entry_bytes(victim);
            set_total++;
            evict_total++;
          end else begin
            r.status = ST_NO_SPACE;
          end
        end
      end
      F_DEL: begin
        if (m >= 0) begin
          byte_sum -= entry_bytes(m);
          slot_used[m] = 1'b0;
          slot_hit_cnt[m] = '0;
          occupied--;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      F_RST: begin
        for (int i = 0; i < Entries; i++) begin
          slot_used[i] = 1'b0;
          slot_hit_cnt[i] = '0;
        end
        occupied = '0;
        byte_sum = '0;
      end
    endcase
    r.hits = hit_total;
    r.accesses = access_total;
    r.sets = set_total;
    r.evictions = evict_total;
    r.key_count = occupied;
    r.bytes_used = byte_sum;
    return r;
  endfunction

  function automatic string show_result(result_t r);
    return $sformatf("status=%0d value=%h hits=%0d gets=%0d sets=%0d evict=%0d keys=%0d bytes=%0d",
                     r.status, r.read_value, r.hits, r.accesses, r.sets, r.evictions,
                     r.key_count, r.bytes_used);
  endfunction

  // All driving tasks are entered and left right after a rising edge.
  task automatic send_item(logic [1:0] op, logic [KeyW-1:0] key, logic [KeyLenW-1:0] klen,
                           logic [ValW-1:0] val, logic [ValLenW-1:0] vlen);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'b0, vlen, val, klen, key};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(cache_apply(op, key, klen, val, vlen));
  endtask

  task automatic random_item();
    logic [1:0] op;
    logic [KeyW-1:0] key;
    logic [ValLenW-1:0] vlen;
    int pick;
    pick = $urandom_range(99);
    op = (pick < 40) ? F_GET : (pick < 78) ? F_SET : (pick < 97) ? F_DEL : F_RST;
    pick = $urandom_range(99);
    if (pick < 88) key = key_pool[$urandom_range(PoolSize - 1)];
    else if (pick < 96) key = {$urandom, $urandom};
    else key = '0;
    // half the lengths are drawn within the current limit
    if ($urandom_range(1) == 1) vlen = ValLenW'($urandom_range(limit_q));
    else vlen = ValLenW'($urandom_range(255));
    send_item(op, key, KeyLenW'($urandom_range(15)), {$urandom, $urandom}, vlen);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_limit(logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_q = v;
  endtask

  task automatic test_basic_ops();
    wait_idle();
    write_limit(8'd255);
    send_item(F_GET, key_pool[0], 4'd8, '0, 8'd0);
    send_item(F_SET, key_pool[0], 4'd8, '1, 8'd255);
    send_item(F_GET, key_pool[0], 4'd0, '0, 8'd0);
    send_item(F_SET, key_pool[0], 4'd15, 64'h0123_4567_89ab_cdef, 8'd0);  // length saturates
    send_item(F_GET, key_pool[0], 4'd3, '1, 8'd255);
    send_item(F_GET, '0, 4'd8, '0, 8'd0);
    send_item(F_SET, '0, 4'd8, 64'h55, 8'd5);
    send_item(F_DEL, '0, 4'd0, '0, 8'd0);
    send_item(F_DEL, key_pool[1], 4'd8, '0, 8'd0);
    send_item(F_SET, '1, 4'd0, '0, 8'd1);
    send_item(F_GET, '1, 4'd8, '0, 8'd0);
  endtask

  task automatic test_value_limit();
    wait_idle();
    write_limit(8'd10);
    send_item(F_SET, key_pool[1], 4'd8, 64'hdead_beef, 8'd11);
    send_item(F_SET, '0, 4'd8, 64'hdead_beef, 8'd11);  // length beats empty key
    send_item(F_SET, key_pool[1], 4'd8, 64'hdead_beef, 8'd10);
    wait_idle();
    write_limit(8'd0);
    send_item(F_SET, key_pool[1], 4'd2, 64'hfeed, 8'd1);
    send_item(F_SET, key_pool[1], 4'd2, 64'hfeed, 8'd0);
  endtask

  task automatic test_delete_and_clear();
    wait_idle();
    write_limit(8'd255);
    send_item(F_DEL, key_pool[0], 4'd0, '0, 8'd0);
    send_item(F_GET, key_pool[0], 4'd0, '0, 8'd0);
    send_item(F_RST, key_pool[1], 4'd8, '1, 8'd9);
    send_item(F_GET, key_pool[1], 4'd0, '0, 8'd0);
    send_item(F_SET, key_pool[0], 4'd4, 64'h1234, 8'd200);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, logic [7:0] lim_a,
                                     logic [7:0] lim_b, int n);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    wait_idle();
    write_limit(lim_a);
    repeat (n) random_item();
    wait_idle();
    write_limit(lim_b);
    repeat (n) random_item();
  endtask

  // Receiver holds off for a long stretch while items keep coming.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    recv_hold_req = HoldCycles;
    repeat (40) random_item();
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_value_limit();
    test_delete_and_clear();
    test_random_traffic(0, 0, 8'd255, 8'($urandom_range(255)), 210);
    test_random_traffic(79, 0, 8'd0, 8'd255, 210);
    test_output_stall();
    test_random_traffic(0, 79, 8'd1, 8'd254, 210);
    test_random_traffic(12, 12, 8'($urandom_range(255)), 8'd128, 210);
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("lfu_key_value_cache_tb: clean");
    end else begin
      $display("lfu_key_value_cache_tb: errors");
    end
    $finish;
  end

  int hold_left = 0;
  always @(posedge clk) begin
    if (recv_hold_req > 0) begin
      hold_left = recv_hold_req;
      recv_hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.read_value = m_axis_tdata[63:0];
      got.hits = m_axis_tdata[95:64];
      got.accesses = m_axis_tdata[127:96];
      got.sets = m_axis_tdata[159:128];
      got.evictions = m_axis_tdata[191:160];
      got.key_count = m_axis_tdata[196:192];
      got.bytes_used = m_axis_tdata[212:197];
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("result %0d arrived with none pending: %s", results_seen, show_result(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("result %0d mismatch", results_seen);
            $display("  expected %s", show_result(want));
            $display("  actual   %s", show_result(got));
          end
        end
      end
      results_seen++;
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("lfu_key_value_cache_tb: errors");
      $finish;
    end
  end

endmodule
